// ----- rtl/mt_twist_pkg.sv -----
// Shared types and constants for the MT19937 state twist core.
package mt_twist_pkg;

	localparam int WORD_W  = 32;
	localparam int INDEX_W = 10;

	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7FFF_FFFF;

	// Input item operation codes
	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_TWIST = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [WORD_W-1:0] load_word;
	} in_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0]  new_word;
		logic [INDEX_W-1:0] word_index;
		logic               pass_done;
	} out_beat_t;

endpackage

// ----- rtl/mt19937_state_twist_core.sv -----
// Top level of the MT19937 state twist core: ring of state cells plus output register.
//
// Usage:
//   in_valid/in_ready/in_data carry one beat per item: mode selects a seed load
//   of load_word or a twist of the word at the current position.
//   out_valid/out_ready/out_data return one beat per item: the word written, its
//   position and a flag raised on the last position of a pass.
// Structure:
//   The state is a ring of STATE_WORDS cells. Cell 0 always holds the word at the
//   current position; cell k holds the word k places on. Each accepted item
//   loads load_word or twists cells 0, 1 and the middle offset into the new
//   word, then the ring rotates by one, the new word entering the last cell.
// Timing:
//   The registered result beat appears in the cycle after the input beat is
//   taken. One item per cycle while out_ready is high; the rate is set by the
//   combinational recurrence over the ring head feeding the rotation.
// Reset:
//   Position and output valid clear; state words are undefined until loaded.
// Stall:
//   While a result waits and out_ready is low, in_ready drops; the ring holds.
module mt19937_state_twist_core
	import mt_twist_pkg::*;
#(
	parameter int STATE_WORDS   = 624,
	parameter int MIDDLE_OFFSET = 397
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam int POS_W   = $clog2(STATE_WORDS);
	localparam int NEXT_IX = 1 % STATE_WORDS;
	localparam int MID_IX  = MIDDLE_OFFSET % STATE_WORDS;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(STATE_WORDS - 1);

	logic [WORD_W-1:0] ring_word [STATE_WORDS];
	logic [WORD_W-1:0] new_word;
	logic [POS_W-1:0]  pos_q;
	logic              accept;
	logic              last_pos;
	logic              out_valid_q;
	out_beat_t         out_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign last_pos = (pos_q == LAST_POS);

	// ring of state cells, rotating toward cell 0 on every accepted beat
	for (genvar k = 0; k < STATE_WORDS; k++) begin : g_cell
		logic [WORD_W-1:0] shift_in;
		if (k == STATE_WORDS - 1) begin : g_tail
			assign shift_in = new_word;
		end else begin : g_link
			assign shift_in = ring_word[k+1];
		end
		mt_twist_cell u_cell (
			.clk      (clk),
			.shift_en (accept),
			.shift_in (shift_in),
			.word     (ring_word[k])
		);
	end

	// new word for the head position
	mt_twist_unit u_unit (
		.mode      (in_data.mode),
		.load_word (in_data.load_word),
		.head_word (ring_word[0]),
		.next_word (ring_word[NEXT_IX]),
		.mid_word  (ring_word[MID_IX]),
		.new_word  (new_word)
	);

	// current position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= last_pos ? '0 : pos_q + POS_W'(1);
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.new_word   <= new_word;
			out_q.word_index <= INDEX_W'(pos_q);
			out_q.pass_done  <= last_pos;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/mt_twist_cell.sv -----
// One state cell of the ring: holds a word and takes its neighbor's word on a shift.
module mt_twist_cell
	import mt_twist_pkg::*;
(
	input  logic              clk,
	input  logic              shift_en,
	input  logic [WORD_W-1:0] shift_in,
	output logic [WORD_W-1:0] word
);

	logic [WORD_W-1:0] word_q;

	// state word, undefined until first written
	always_ff @(posedge clk) begin
		if (shift_en) begin
			word_q <= shift_in;
		end
	end

	assign word = word_q;

endmodule

// ----- rtl/mt_twist_unit.sv -----
// Recurrence logic: seed word or twisted word from the head, next and middle words.
module mt_twist_unit
	import mt_twist_pkg::*;
(
	input  mode_t             mode,
	input  logic [WORD_W-1:0] load_word,
	input  logic [WORD_W-1:0] head_word,
	input  logic [WORD_W-1:0] next_word,
	input  logic [WORD_W-1:0] mid_word,
	output logic [WORD_W-1:0] new_word
);

	logic [WORD_W-1:0] joined;
	logic [WORD_W-1:0] mixed;

	// top bit of the head word, low bits of its successor
	assign joined = (head_word & UPPER_MASK) | (next_word & LOWER_MASK);

	always_comb begin
		mixed = mid_word ^ (joined >> 1);
		if (joined[0]) begin
			mixed = mixed ^ TWIST_MATRIX;
		end
	end

	always_comb begin
		unique case (mode)
			MODE_LOAD:  new_word = load_word;
			MODE_TWIST: new_word = mixed;
			default:    new_word = mixed;
		endcase
	end

endmodule

// ----- sim/tb_mt19937_state_twist_core.sv -----
// Testbench for the MT19937 state twist core: directed and random load/twist traffic checked against a state mirror.
module tb_mt19937_state_twist_core;
	import mt_twist_pkg::*;

	localparam int N_WORDS     = 624;
	localparam int MID_OFS     = 397;
	localparam int N_ITEMS     = 1000;
	localparam int MAX_IDLE    = 15;
	localparam int DRAIN_TICKS = 20;

	// Shadow of the ring state; predicts each result beat and checks it in order
	class twist_scoreboard;
		logic [WORD_W-1:0] words [N_WORDS];
		bit                written [N_WORDS];
		int                pos;
		out_beat_t         awaited_beats [$];
		int                mismatches;
		int                checked;
		int                loads;
		int                twists;
		int                passes;

		function new();
			pos = 0;
			mismatches = 0;
			checked = 0;
			loads = 0;
			twists = 0;
			passes = 0;
			foreach (written[k])
				written[k] = 1'b0;
		endfunction

		// A twist here only reads words already written since reset
		function bit twist_legal();
			return written[pos] && written[(pos + 1) % N_WORDS]
				&& written[(pos + MID_OFS % N_WORDS) % N_WORDS];
		endfunction

		// Published recurrence over the current, next and middle words
		function logic [WORD_W-1:0] regenerate(int idx);
			logic [WORD_W-1:0] joined;
			logic [WORD_W-1:0] mixed;
			joined = (words[idx] & UPPER_MASK) | (words[(idx + 1) % N_WORDS] & LOWER_MASK);
			mixed  = words[(idx + MID_OFS % N_WORDS) % N_WORDS] ^ (joined >> 1);
			if (joined[0])
				mixed = mixed ^ TWIST_MATRIX;
			return mixed;
		endfunction

		function void note_input(in_beat_t b);
			out_beat_t exp_beat;
			logic [WORD_W-1:0] w;
			if (b.mode == MODE_LOAD) begin
				w = b.load_word;
				loads++;
			end else begin
				w = regenerate(pos);
				twists++;
			end
			words[pos] = w;
			written[pos] = 1'b1;
			exp_beat.new_word   = w;
			exp_beat.word_index = pos[INDEX_W-1:0];
			exp_beat.pass_done  = (pos == N_WORDS - 1);
			awaited_beats.push_back(exp_beat);
			pos = (pos == N_WORDS - 1) ? 0 : pos + 1;
		endfunction

		function void check_output(out_beat_t got);
			out_beat_t exp_beat;
			if (awaited_beats.size() == 0) begin
				$error("result beat with nothing expected: new_word %h word_index %0d",
					got.new_word, got.word_index);
				mismatches++;
				return;
			end
			exp_beat = awaited_beats.pop_front();
			checked++;
			if (got.pass_done === 1'b1)
				passes++;
			if (got.new_word !== exp_beat.new_word) begin
				$error("new_word: expected %h, got %h", exp_beat.new_word, got.new_word);
				mismatches++;
			end
			if (got.word_index !== exp_beat.word_index) begin
				$error("word_index: expected %0d, got %0d", exp_beat.word_index, got.word_index);
				mismatches++;
			end
			if (got.pass_done !== exp_beat.pass_done) begin
				$error("pass_done: expected %b, got %b", exp_beat.pass_done, got.pass_done);
				mismatches++;
			end
		endfunction

		function int pending();
			return awaited_beats.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;

	// no idling on either side while set
	bit calm;

	twist_scoreboard sb = new();

	mt19937_state_twist_core #(
		.STATE_WORDS  (N_WORDS),
		.MIDDLE_OFFSET(MID_OFS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// 8-unit clock
	always #4 clk = ~clk;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		calm = 1'b0;
	end

	// Send one input beat after a random gap; returns once it is taken
	task automatic send_beat(in_beat_t b);
		int gap;
		gap = calm ? 0 : $urandom_range(MAX_IDLE);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(b);
	endtask

	function automatic logic [WORD_W-1:0] pick_seed();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return ($urandom_range(1) != 0) ? UPPER_MASK : LOWER_MASK;
			default: return $urandom();
		endcase
	endfunction

	// Result side: random stall per beat, then check what is taken
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(MAX_IDLE);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			sb.check_output(out_data);
		end
	end

	// Stimulus and end of run
	initial begin
		in_beat_t b;
		logic [WORD_W-1:0] corner_seeds [$];
		int n;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corner seed words at the head of the state; a twist needs a
		// fully seeded state, so twists start only once the first pass is loaded
		corner_seeds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_0001, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h9908_B0DF, 32'h66F7_4F20, 32'h8000_0001, 32'h7FFF_FFFE,
			32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000};
		n = 0;
		foreach (corner_seeds[k]) begin
			b.mode = MODE_LOAD;
			b.load_word = corner_seeds[k];
			send_beat(b);
			n++;
		end

		// Random: loads until twists are legal, then mostly twists with some reseeds
		while (n < N_ITEMS) begin
			if (n % 100 == 0)
				calm = ($urandom_range(3) == 0);
			b.load_word = $urandom();
			if (!sb.twist_legal())
				b.mode = MODE_LOAD;
			else
				b.mode = ($urandom_range(99) < 85) ? MODE_TWIST : MODE_LOAD;
			if (b.mode == MODE_LOAD)
				b.load_word = pick_seed();
			send_beat(b);
			n++;
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		// Drain, then wait for any stray beat
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);

		$display("Run: %0d seed loads and %0d twists, %0d result beats checked,",
			sb.loads, sb.twists, sb.checked);
		$display("     %0d completed passes over the %0d-word state", sb.passes, N_WORDS);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/mt_twist_pkg.sv
rtl/mt_twist_cell.sv
rtl/mt_twist_unit.sv
rtl/mt19937_state_twist_core.sv
sim/tb_mt19937_state_twist_core.sv
